// ----- hdl/ubx_frame_parser_top_macros.svh -----
// Assertion macros shared by the frame parser modules.
// Expects i_clk and i_rst_n in the including module's scope.
`ifndef UBX_FRAME_PARSER_TOP_MACROS_SVH
`define UBX_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, off while in reset.
`define UBXFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Next-cycle implication, off while in reset.
`define UBXFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`endif

// ----- hdl/ubxfp_pkg.sv -----
// Package for the UBX frame parser: constants, parse phases, register indexes
// and the result record passed from the parser core to the output stage.
// No dependencies.
package ubxfp_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [15:0] LON_START  = 16'd4;
    localparam logic [15:0] LAT_START  = 16'd8;
    localparam logic [15:0] COORD_END  = 16'd12;
    localparam logic [15:0] FIX_OFFSET = 16'd4;

    localparam logic [15:0] POSITION_ID_RST = 16'h0102;
    localparam logic [15:0] STATUS_ID_RST   = 16'h0103;
    localparam logic [7:0]  FIX_LOWER_RST   = 8'd1;
    localparam logic [7:0]  FIX_UPPER_RST   = 8'd5;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 152;
    localparam int OUT_PAD_W   = 7;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN1,
        PH_LEN2,
        PH_PAYLOAD,
        PH_CKA,
        PH_CKB
    } t_phase;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_POSITION_ID,
        CFG_STATUS_ID,
        CFG_FIX_LOWER,
        CFG_FIX_UPPER
    } t_cfg_index;

    typedef struct packed {
        logic               frame_status;
        logic [15:0]        msg_id;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic               fix_valid;
        logic [15:0]        good_fix_total;
        logic [15:0]        bad_fix_total;
        logic [15:0]        ck_pass_total;
        logic [15:0]        ck_fail_total;
    } t_result;

endpackage

// ----- hdl/ubxfp_core.sv -----
// Byte-wise UBX parser core: sync hunt, header, Fletcher checksum, payload
// decode, fix and checksum counters, config registers. Uses ubxfp_pkg.
`include "ubx_frame_parser_top_macros.svh"

module ubxfp_core #(
    parameter int COUNT_WIDTH = ubxfp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [7:0]                          i_byte,
    input  logic                                i_cfg_we,
    input  logic [ubxfp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ubxfp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                                o_res_valid,
    output ubxfp_pkg::t_result                  o_res
);

    ubxfp_pkg::t_phase r_phase, n_phase;
    logic [15:0]        r_frame_id, n_frame_id;
    logic [15:0]        r_payload_len, n_payload_len;
    logic [15:0]        r_offset, n_offset;
    logic [7:0]         r_sum_a, n_sum_a;
    logic [7:0]         r_sum_b, n_sum_b;
    logic [31:0]        r_lat, n_lat;
    logic [31:0]        r_lon, n_lon;
    logic               r_fix, n_fix;
    logic [COUNT_WIDTH-1:0] r_good, n_good;
    logic [COUNT_WIDTH-1:0] r_bad, n_bad;
    logic [COUNT_WIDTH-1:0] r_pass, n_pass;
    logic [COUNT_WIDTH-1:0] r_fail, n_fail;

    logic [15:0] r_pos_id;
    logic [15:0] r_stat_id;
    logic [7:0]  r_fix_lo;
    logic [7:0]  r_fix_hi;

    logic        n_res_valid;
    logic        n_status;

    // Running Fletcher sums with this byte folded in
    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] offset_inc;

    assign sum_a_add  = r_sum_a + i_byte;
    assign sum_b_add  = r_sum_b + sum_a_add;
    assign offset_inc = r_offset + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_id  <= ubxfp_pkg::POSITION_ID_RST;
            r_stat_id <= ubxfp_pkg::STATUS_ID_RST;
            r_fix_lo  <= ubxfp_pkg::FIX_LOWER_RST;
            r_fix_hi  <= ubxfp_pkg::FIX_UPPER_RST;
        end else if (i_cfg_we) begin
            case (ubxfp_pkg::t_cfg_index'(i_cfg_index))
                ubxfp_pkg::CFG_POSITION_ID: r_pos_id  <= i_cfg_wdata;
                ubxfp_pkg::CFG_STATUS_ID:   r_stat_id <= i_cfg_wdata;
                ubxfp_pkg::CFG_FIX_LOWER:   r_fix_lo  <= i_cfg_wdata[7:0];
                ubxfp_pkg::CFG_FIX_UPPER:   r_fix_hi  <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic [31:0] lat_base;
        logic [31:0] lon_base;
        logic [4:0]  lane_sh;

        n_phase       = r_phase;
        n_frame_id    = r_frame_id;
        n_payload_len = r_payload_len;
        n_offset      = r_offset;
        n_sum_a       = r_sum_a;
        n_sum_b       = r_sum_b;
        n_lat         = r_lat;
        n_lon         = r_lon;
        n_fix         = r_fix;
        n_good        = r_good;
        n_bad         = r_bad;
        n_pass        = r_pass;
        n_fail        = r_fail;
        n_res_valid   = 1'b0;
        n_status      = 1'b0;
        lane_sh       = {r_offset[1:0], 3'b000};
        // Clear the fix flag and coordinates at the first payload byte
        lat_base      = (r_offset == 16'd0) ? 32'd0 : r_lat;
        lon_base      = (r_offset == 16'd0) ? 32'd0 : r_lon;

        if (i_valid) begin
            case (r_phase)
                ubxfp_pkg::PH_SYNC2: begin
                    if (i_byte == ubxfp_pkg::SYNC_SECOND) begin
                        n_phase = ubxfp_pkg::PH_CLASS;
                    end else begin
                        n_phase  = ubxfp_pkg::PH_SYNC1;
                        n_offset = 16'd0;
                        n_sum_a  = 8'd0;
                        n_sum_b  = 8'd0;
                    end
                end
                ubxfp_pkg::PH_CLASS: begin
                    n_frame_id = {i_byte, 8'd0};
                    n_sum_a    = sum_a_add;
                    n_sum_b    = sum_b_add;
                    n_phase    = ubxfp_pkg::PH_ID;
                end
                ubxfp_pkg::PH_ID: begin
                    n_frame_id = {r_frame_id[15:8], i_byte};
                    n_sum_a    = sum_a_add;
                    n_sum_b    = sum_b_add;
                    n_phase    = ubxfp_pkg::PH_LEN1;
                end
                ubxfp_pkg::PH_LEN1: begin
                    n_payload_len = {8'd0, i_byte};
                    n_sum_a       = sum_a_add;
                    n_sum_b       = sum_b_add;
                    n_phase       = ubxfp_pkg::PH_LEN2;
                end
                ubxfp_pkg::PH_LEN2: begin
                    n_payload_len = {i_byte, r_payload_len[7:0]};
                    n_sum_a       = sum_a_add;
                    n_sum_b       = sum_b_add;
                    n_offset      = 16'd0;
                    // Empty payload goes straight to the checksum
                    n_phase = ({i_byte, r_payload_len[7:0]} == 16'd0) ?
                              ubxfp_pkg::PH_CKA : ubxfp_pkg::PH_PAYLOAD;
                end
                ubxfp_pkg::PH_PAYLOAD: begin
                    if (r_offset == 16'd0) begin
                        n_fix = 1'b0;
                        n_lat = 32'd0;
                        n_lon = 32'd0;
                    end
                    if (r_frame_id == r_pos_id) begin
                        if (r_offset >= ubxfp_pkg::LAT_START &&
                            r_offset < ubxfp_pkg::COORD_END) begin
                            n_lat = lat_base;
                            n_lat[lane_sh +: 8] = i_byte;
                        end else if (r_offset >= ubxfp_pkg::LON_START &&
                                     r_offset < ubxfp_pkg::LAT_START) begin
                            n_lon = lon_base;
                            n_lon[lane_sh +: 8] = i_byte;
                        end
                    end else if (r_frame_id == r_stat_id) begin
                        if (r_offset == ubxfp_pkg::FIX_OFFSET) begin
                            if (i_byte > r_fix_lo && i_byte < r_fix_hi) begin
                                n_good = (r_good == '1) ? r_good : r_good + 1'b1;
                                n_fix  = 1'b1;
                            end else begin
                                n_bad = (r_bad == '1) ? r_bad : r_bad + 1'b1;
                            end
                        end
                    end
                    n_sum_a  = sum_a_add;
                    n_sum_b  = sum_b_add;
                    n_offset = offset_inc;
                    if (offset_inc >= r_payload_len) begin
                        n_phase = ubxfp_pkg::PH_CKA;
                    end
                end
                ubxfp_pkg::PH_CKA: begin
                    if (i_byte != r_sum_a) begin
                        n_fail      = (r_fail == '1) ? r_fail : r_fail + 1'b1;
                        n_res_valid = 1'b1;
                        n_status    = 1'b1;
                        n_phase     = ubxfp_pkg::PH_SYNC1;
                        n_offset    = 16'd0;
                        n_sum_a     = 8'd0;
                        n_sum_b     = 8'd0;
                    end else begin
                        n_phase = ubxfp_pkg::PH_CKB;
                    end
                end
                ubxfp_pkg::PH_CKB: begin
                    if (i_byte != r_sum_b) begin
                        n_fail   = (r_fail == '1) ? r_fail : r_fail + 1'b1;
                        n_status = 1'b1;
                    end else begin
                        n_pass = (r_pass == '1) ? r_pass : r_pass + 1'b1;
                    end
                    n_res_valid = 1'b1;
                    n_phase     = ubxfp_pkg::PH_SYNC1;
                    n_offset    = 16'd0;
                    n_sum_a     = 8'd0;
                    n_sum_b     = 8'd0;
                end
                default: begin
                    n_offset = 16'd0;
                    n_sum_a  = 8'd0;
                    n_sum_b  = 8'd0;
                    n_phase  = (i_byte == ubxfp_pkg::SYNC_FIRST) ?
                               ubxfp_pkg::PH_SYNC2 : ubxfp_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ubxfp_pkg::PH_SYNC1;
            r_frame_id    <= '0;
            r_payload_len <= '0;
            r_offset      <= '0;
            r_sum_a       <= '0;
            r_sum_b       <= '0;
            r_lat         <= '0;
            r_lon         <= '0;
            r_fix         <= 1'b0;
            r_good        <= '0;
            r_bad         <= '0;
            r_pass        <= '0;
            r_fail        <= '0;
        end else begin
            r_phase       <= n_phase;
            r_frame_id    <= n_frame_id;
            r_payload_len <= n_payload_len;
            r_offset      <= n_offset;
            r_sum_a       <= n_sum_a;
            r_sum_b       <= n_sum_b;
            r_lat         <= n_lat;
            r_lon         <= n_lon;
            r_fix         <= n_fix;
            r_good        <= n_good;
            r_bad         <= n_bad;
            r_pass        <= n_pass;
            r_fail        <= n_fail;
        end
    end

    assign o_res_valid          = n_res_valid;
    assign o_res.frame_status   = n_status;
    assign o_res.msg_id         = r_frame_id;
    assign o_res.lat            = r_lat;
    assign o_res.lon            = r_lon;
    assign o_res.fix_valid      = r_fix;
    assign o_res.good_fix_total = 16'(n_good);
    assign o_res.bad_fix_total  = 16'(n_bad);
    assign o_res.ck_pass_total  = 16'(n_pass);
    assign o_res.ck_fail_total  = 16'(n_fail);

    `UBXFP_ASSERT_NOW(a_res_only_at_ck, n_res_valid, (r_phase == ubxfp_pkg::PH_CKA) || (r_phase == ubxfp_pkg::PH_CKB))
    `UBXFP_ASSERT_NOW(a_payload_nonempty, r_phase == ubxfp_pkg::PH_PAYLOAD, r_payload_len != 16'd0)
    `UBXFP_ASSERT_NOW(a_hunt_sums_clear, (r_phase == ubxfp_pkg::PH_SYNC1) || (r_phase == ubxfp_pkg::PH_SYNC2), (r_sum_a == 8'd0) && (r_sum_b == 8'd0))

endmodule

// ----- hdl/ubx_frame_parser_top.sv -----
// ubx_frame_parser_top: stream wrapper around the UBX parser core with a
// result register that decouples the two stream sides. Uses ubxfp_pkg, ubxfp_core.
//
//  channel   dir  handshake                fields
//  s_axis    in   tvalid/tready            tdata: rx_byte
//  m_axis    out  tvalid/tready            tuser: frame_status; tdata: see port
//  cfg       in   we (no wait)             index 0..3, wdata 16 bit
//
// One byte is taken per cycle; a result appears in the cycle after the
// checksum byte that ends its frame. The single result register sets the rate:
// a byte is refused only while a result waits and the sink is stalled.
// Reset is synchronous and active low; no clearing pass.
`include "ubx_frame_parser_top_macros.svh"

module ubx_frame_parser_top #(
    parameter int COUNT_WIDTH = ubxfp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [ubxfp_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,   // [7:0] rx_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] msg_id, [47:16] lat_out, [79:48] lon_out, [80] fix_valid,
    // [96:81] good_fix_total, [112:97] bad_fix_total, [128:113] ck_pass_total,
    // [144:129] ck_fail_total, [151:145] zero
    output logic [ubxfp_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tuser,   // [0] frame_status
    input  logic                                i_cfg_we,
    input  logic [ubxfp_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ubxfp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    logic               in_xfer;
    logic               res_valid;
    ubxfp_pkg::t_result res;
    ubxfp_pkg::t_result r_out;
    logic               r_out_valid;

    // Take a byte when the result slot is free or drains this cycle
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    ubxfp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_xfer),
        .i_byte      (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.frame_status;
    assign o_m_axis_tdata  = {{ubxfp_pkg::OUT_PAD_W{1'b0}},
                              r_out.ck_fail_total,
                              r_out.ck_pass_total,
                              r_out.bad_fix_total,
                              r_out.good_fix_total,
                              r_out.fix_valid,
                              r_out.lon,
                              r_out.lat,
                              r_out.msg_id};

    `UBXFP_ASSERT_NOW(a_stall_only_when_full, !o_s_axis_tready, r_out_valid)
    `UBXFP_ASSERT_NEXT(a_result_loaded, in_xfer && res_valid, r_out_valid)
    `UBXFP_ASSERT_NEXT(a_result_kept, r_out_valid && !i_m_axis_tready, r_out_valid)

endmodule
